[rtl/vsreb_pkg.sv]
// types and constants shared by the vertex shift and round block
`timescale 1ns / 1ps
`default_nettype none

package vsreb_pkg;

	typedef struct packed {
		logic [63:0] coord_x;
		logic [63:0] coord_y;
		logic [63:0] coord_z;
	} in_word_t;

	typedef struct packed {
		logic [31:0] out_x;
		logic [31:0] out_y;
		logic [31:0] out_z;
		logic [31:0] error_bound;
	} out_word_t;

	typedef logic [1:0] cfg_idx_t;

	localparam cfg_idx_t CFG_CENTER_X = 2'd0;
	localparam cfg_idx_t CFG_CENTER_Y = 2'd1;
	localparam cfg_idx_t CFG_CENTER_Z = 2'd2;
	localparam cfg_idx_t CFG_PRECISE  = 2'd3;

	localparam logic [63:0] D_QUIET_BIT   = 64'h0008_0000_0000_0000;
	localparam logic [63:0] D_DEFAULT_NAN = 64'hFFF8_0000_0000_0000;
	localparam logic [62:0] D_NARROW_OVF  = 63'h47EF_FFFF_F000_0000;
	localparam logic [31:0] F_QUIET_BIT   = 32'h0040_0000;
	localparam logic [31:0] F_QNAN        = 32'h7FC0_0000;
	localparam logic [31:0] F_INF         = 32'h7F80_0000;

endpackage

`default_nettype wire

[rtl/vertex_shift_round_error_bound.sv]
// vertex shift by a double center, rounding to single and error bound pipeline
//
//  channel  | handshake               | payload
//  ---------+-------------------------+-----------------------------------
//  in       | in_valid / in_stall     | in_word  (three double coords)
//  out      | out_valid / out_stall   | out_word (three singles, bound)
//  cfg      | cfg_we                  | cfg_idx, cfg_data
//
// eleven register stages; one word enters per cycle whenever in_stall is low.
// of them, the double subtract takes six stages, narrowing and residual two,
// max and guard one, the final single add two.
// reset clears the valid bits and the configuration registers.
// each stage holds while the next one is full and stalled; bubbles close up.
`timescale 1ns / 1ps
`default_nettype none

module vertex_shift_round_error_bound (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire vsreb_pkg::cfg_idx_t  cfg_idx,
	input  wire logic [63:0]          cfg_data,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire vsreb_pkg::in_word_t  in_word,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output vsreb_pkg::out_word_t      out_word
);

	localparam int NS = 11;

	typedef struct packed {
		logic        spec;
		logic [63:0] spec_val;
		logic        sub;
		logic        sign;
		logic [10:0] exp;
		logic [52:0] man_l;
		logic [52:0] man_s;
		logic [10:0] diff;
	} dsub1_t;

	typedef struct packed {
		logic        spec;
		logic [63:0] spec_val;
		logic        sub;
		logic        sign;
		logic [10:0] exp;
		logic [55:0] big;
		logic [55:0] small_m;
	} dsub2_t;

	typedef struct packed {
		logic        spec;
		logic [63:0] spec_val;
		logic        sign;
		logic [10:0] exp;
		logic [56:0] sum;
	} dsub3_t;

	typedef struct packed {
		logic        spec;
		logic [63:0] spec_val;
		logic        sign;
		logic [10:0] exp;
		logic [56:0] sum;
		logic [5:0]  sh;
	} dsub4_t;

	typedef struct packed {
		logic        spec;
		logic [63:0] spec_val;
		logic        sign;
		logic [11:0] exp;
		logic [55:0] m;
	} dsub5_t;

	typedef struct packed {
		logic [31:0] fx;
		logic        efix;
		logic [31:0] efix_val;
		logic [7:0]  ef;
		logic [28:0] r;
	} nar_t;

	typedef struct packed {
		logic [2:0][31:0] fx;
		logic [31:0]      emax;
		logic [31:0]      guard;
	} fin9_t;

	typedef struct packed {
		logic [2:0][31:0] fx;
		logic             spec;
		logic [31:0]      spec_val;
		logic [7:0]       el;
		logic [27:0]      sum;
	} fin10_t;

	typedef struct packed {
		logic [63:0] kept;
		logic        ru;
	} rnd_t;

	function automatic rnd_t shr_rne(input logic [63:0] x, input logic [6:0] amt);
		rnd_t        r;
		logic [63:0] rem;
		logic [63:0] half;
		logic        g;
		logic        st;
		r.kept = x >> amt;
		rem    = x & ~({64{1'b1}} << amt);
		half   = (amt == 7'd0) ? 64'd0 : (64'd1 << (amt - 7'd1));
		g      = |(rem & half);
		st     = |(rem & (half - 64'd1));
		r.ru   = g & (st | r.kept[0]);
		return r;
	endfunction

	function automatic logic [5:0] lzc56(input logic [55:0] v);
		logic [5:0] n;
		n = 6'd56;
		for (int i = 0; i < 56; i++) begin
			if (v[i]) n = 6'(55 - i);
		end
		return n;
	endfunction

	function automatic logic [4:0] lzc29(input logic [28:0] v);
		logic [4:0] n;
		n = 5'd29;
		for (int i = 0; i < 29; i++) begin
			if (v[i]) n = 5'(28 - i);
		end
		return n;
	endfunction

	function automatic logic f_nan(input logic [31:0] x);
		return (&x[30:23]) && (|x[22:0]);
	endfunction

	function automatic logic f_lt(input logic [31:0] m, input logic [31:0] b);
		return !f_nan(m) && !f_nan(b) && (m[30:0] < b[30:0]);
	endfunction

	logic [63:0] center_q [3];
	logic        precise_q;
	logic [NS:1] stage_vld_q;
	logic [NS:1] adv;
	logic [63:0] coord [3];

	dsub1_t      d1_s1 [3];
	dsub2_t      d2_s2 [3];
	dsub3_t      d3_s3 [3];
	dsub4_t      d4_s4 [3];
	dsub5_t      d5_s5 [3];
	logic [63:0] sx_s6 [3];
	nar_t        n_s7  [3];
	logic [31:0] fx_s8 [3];
	logic [31:0] err_s8 [3];
	fin9_t       f_s9;
	fin10_t      f_s10;
	vsreb_pkg::out_word_t out_s11;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) center_q[i] <= 64'd0;
			precise_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_idx)
				vsreb_pkg::CFG_CENTER_X: center_q[0] <= cfg_data;
				vsreb_pkg::CFG_CENTER_Y: center_q[1] <= cfg_data;
				vsreb_pkg::CFG_CENTER_Z: center_q[2] <= cfg_data;
				vsreb_pkg::CFG_PRECISE:  precise_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// stage enables, a stage moves when empty or when the next one moves
	always_comb begin
		adv[NS] = !stage_vld_q[NS] || !out_stall;
		for (int k = NS - 1; k >= 1; k--) adv[k] = !stage_vld_q[k] || adv[k + 1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_vld_q <= '0;
		end else begin
			if (adv[1]) stage_vld_q[1] <= in_valid;
			for (int k = 2; k <= NS; k++) begin
				if (adv[k]) stage_vld_q[k] <= stage_vld_q[k - 1];
			end
		end
	end

	assign in_stall  = !adv[1];
	assign out_valid = stage_vld_q[NS];
	assign out_word  = out_s11;

	assign coord[0] = in_word.coord_x;
	assign coord[1] = in_word.coord_y;
	assign coord[2] = in_word.coord_z;

	for (genvar i = 0; i < 3; i++) begin : g_lane
		dsub1_t      n1;
		dsub2_t      n2;
		dsub3_t      n3;
		dsub4_t      n4;
		dsub5_t      n5;
		logic [63:0] n6;
		nar_t        n7;
		logic [31:0] n8;
		logic [63:0] a;
		logic [63:0] b;
		logic        a_nan, a_inf, b_nan, b_inf;
		logic [63:0] lw, sw;
		logic [10:0] el, es;
		logic [5:0]  d2;
		logic [55:0] x2, sh2;
		logic [10:0] lim4;
		logic [5:0]  lz4;
		logic [11:0] e5;
		logic        ru6;
		logic [10:0] ee7;
		logic        nan7, big7, norm7;
		logic signed [12:0] efs7;
		logic [6:0]  rsh7;
		rnd_t        rr7;
		logic [52:0] m7;
		logic [4:0]  lz8, p8;
		logic signed [9:0] bz8;
		logic        nrm8;
		logic [6:0]  amt8;
		rnd_t        rr8;

		// unpack, specials, order by magnitude
		always_comb begin
			a     = coord[i];
			b     = {~center_q[i][63], center_q[i][62:0]};
			a_nan = (&a[62:52]) && (|a[51:0]);
			a_inf = (&a[62:52]) && !(|a[51:0]);
			b_nan = (&b[62:52]) && (|b[51:0]);
			b_inf = (&b[62:52]) && !(|b[51:0]);
			n1.spec = a_nan || b_nan || a_inf || b_inf;
			if (a_nan) n1.spec_val = a | vsreb_pkg::D_QUIET_BIT;
			else if (b_nan) n1.spec_val = center_q[i] | vsreb_pkg::D_QUIET_BIT;
			else if (a_inf && b_inf && (a[63] != b[63])) n1.spec_val = vsreb_pkg::D_DEFAULT_NAN;
			else if (a_inf) n1.spec_val = a;
			else n1.spec_val = b;
			if (a[62:0] >= b[62:0]) begin
				lw = a;
				sw = b;
			end else begin
				lw = b;
				sw = a;
			end
			el = (lw[62:52] == 11'd0) ? 11'd1 : lw[62:52];
			es = (sw[62:52] == 11'd0) ? 11'd1 : sw[62:52];
			n1.sub   = a[63] ^ b[63];
			n1.sign  = lw[63];
			n1.exp   = el;
			n1.man_l = {|lw[62:52], lw[51:0]};
			n1.man_s = {|sw[62:52], sw[51:0]};
			n1.diff  = el - es;
		end

		// align the smaller operand, sticky into the lsb
		always_comb begin
			d2  = (d1_s1[i].diff > 11'd56) ? 6'd56 : d1_s1[i].diff[5:0];
			x2  = {d1_s1[i].man_s, 3'b000};
			sh2 = x2 >> d2;
			n2.spec     = d1_s1[i].spec;
			n2.spec_val = d1_s1[i].spec_val;
			n2.sub      = d1_s1[i].sub;
			n2.sign     = d1_s1[i].sign;
			n2.exp      = d1_s1[i].exp;
			n2.big      = {d1_s1[i].man_l, 3'b000};
			n2.small_m  = {sh2[55:1], sh2[0] | (|(x2 & ~({56{1'b1}} << d2)))};
		end

		// add or subtract magnitudes
		always_comb begin
			n3.spec     = d2_s2[i].spec;
			n3.spec_val = d2_s2[i].spec_val;
			n3.exp      = d2_s2[i].exp;
			if (d2_s2[i].sub) n3.sum = {1'b0, d2_s2[i].big} - {1'b0, d2_s2[i].small_m};
			else n3.sum = {1'b0, d2_s2[i].big} + {1'b0, d2_s2[i].small_m};
			if (n3.sum == 57'd0) n3.sign = d2_s2[i].sub ? 1'b0 : d2_s2[i].sign;
			else n3.sign = d2_s2[i].sign;
		end

		// leading zero count, limited by the exponent
		always_comb begin
			lz4  = lzc56(d3_s3[i].sum[55:0]);
			lim4 = d3_s3[i].exp - 11'd1;
			n4.spec     = d3_s3[i].spec;
			n4.spec_val = d3_s3[i].spec_val;
			n4.sign     = d3_s3[i].sign;
			n4.exp      = d3_s3[i].exp;
			n4.sum      = d3_s3[i].sum;
			n4.sh       = ({5'd0, lz4} > lim4) ? lim4[5:0] : lz4;
		end

		// normalize
		always_comb begin
			n5.spec     = d4_s4[i].spec;
			n5.spec_val = d4_s4[i].spec_val;
			n5.sign     = d4_s4[i].sign;
			e5          = {1'b0, d4_s4[i].exp} - {6'd0, d4_s4[i].sh};
			if (d4_s4[i].sum[56]) begin
				n5.m   = {d4_s4[i].sum[56:2], |d4_s4[i].sum[1:0]};
				n5.exp = {1'b0, d4_s4[i].exp} + 12'd1;
			end else begin
				n5.m   = d4_s4[i].sum[55:0] << d4_s4[i].sh;
				n5.exp = n5.m[55] ? e5 : 12'd0;
			end
		end

		// round to nearest even and pack the double
		always_comb begin
			ru6 = d5_s5[i].m[2] & ((|d5_s5[i].m[1:0]) | d5_s5[i].m[3]);
			if (d5_s5[i].spec) n6 = d5_s5[i].spec_val;
			else if (d5_s5[i].exp >= 12'd2047) n6 = {d5_s5[i].sign, 11'h7FF, 52'd0};
			else n6 = {d5_s5[i].sign,
				63'({d5_s5[i].exp[10:0], d5_s5[i].m[54:3]}) + 63'(ru6)};
		end

		// narrow to single, keep the residual of a normal result
		always_comb begin
			ee7   = sx_s6[i][62:52];
			nan7  = (&ee7) && (|sx_s6[i][51:0]);
			big7  = sx_s6[i][62:0] >= vsreb_pkg::D_NARROW_OVF;
			efs7  = $signed({2'b00, ee7}) - 13'sd896;
			norm7 = efs7 > 13'sd0;
			m7    = {|ee7, sx_s6[i][51:0]};
			if (norm7) rsh7 = 7'd29;
			else if (efs7 < -13'sd24) rsh7 = 7'd55;
			else rsh7 = 7'(13'sd30 - efs7);
			rr7   = shr_rne({11'd0, m7}, rsh7);
			n7.ef = norm7 ? efs7[7:0] : 8'd0;
			n7.r  = rr7.ru ? 29'(30'h2000_0000 - {1'b0, m7[28:0]}) : m7[28:0];
			if (nan7) begin
				n7.fx       = {sx_s6[i][63], 31'd0} | vsreb_pkg::F_QNAN
					| {9'd0, sx_s6[i][51:29]};
				n7.efix     = 1'b1;
				n7.efix_val = vsreb_pkg::F_QNAN | {9'd0, sx_s6[i][51:29]};
			end else if (big7) begin
				n7.fx       = {sx_s6[i][63], 31'd0} | vsreb_pkg::F_INF;
				n7.efix     = 1'b1;
				n7.efix_val = (&ee7) ? vsreb_pkg::F_QNAN : vsreb_pkg::F_INF;
			end else begin
				n7.fx       = {sx_s6[i][63],
					31'({n7.ef, rr7.kept[22:0]}) + 31'(rr7.ru)};
				n7.efix     = !norm7;
				n7.efix_val = 32'd0;
			end
		end

		// residual to single
		always_comb begin
			lz8  = lzc29(n_s7[i].r);
			p8   = 5'd28 - lz8;
			bz8  = $signed({5'd0, p8}) + $signed({2'b00, n_s7[i].ef}) - 10'sd52;
			nrm8 = bz8 > 10'sd0;
			amt8 = nrm8 ? {2'b00, p8} : 7'(9'd53 - {1'b0, n_s7[i].ef});
			rr8  = shr_rne({12'd0, n_s7[i].r, 23'd0}, amt8);
			if (n_s7[i].efix) n8 = n_s7[i].efix_val;
			else if (n_s7[i].r == 29'd0) n8 = 32'd0;
			else n8 = {1'b0, 31'({(nrm8 ? bz8[7:0] : 8'd0), rr8.kept[22:0]}) + 31'(rr8.ru)};
		end

		always_ff @(posedge clk) begin
			if (adv[1]) d1_s1[i] <= n1;
			if (adv[2]) d2_s2[i] <= n2;
			if (adv[3]) d3_s3[i] <= n3;
			if (adv[4]) d4_s4[i] <= n4;
			if (adv[5]) d5_s5[i] <= n5;
			if (adv[6]) sx_s6[i] <= n6;
			if (adv[7]) n_s7[i] <= n7;
			if (adv[8]) begin
				fx_s8[i]  <= n_s7[i].fx;
				err_s8[i] <= n8;
			end
		end
	end

	fin9_t       n9;
	fin10_t      n10;
	vsreb_pkg::out_word_t n11;
	logic [31:0] mm9, mg9;
	logic [7:0]  e9;
	logic [7:0]  ee9;
	rnd_t        rr9;
	logic [31:0] lw10, sw10;
	logic [7:0]  el10, es10, df10;
	logic [4:0]  d10;
	logic [26:0] x10, sh10;
	logic [23:0] mant11;
	logic        g11, st11, ru11;
	logic [8:0]  e11;
	logic [31:0] tot11;

	// maxima and the epsilon term
	always_comb begin
		mm9 = err_s8[0];
		if (f_lt(mm9, err_s8[1])) mm9 = err_s8[1];
		if (f_lt(mm9, err_s8[2])) mm9 = err_s8[2];
		mg9 = {1'b0, fx_s8[0][30:0]};
		if (f_lt(mg9, {1'b0, fx_s8[1][30:0]})) mg9 = {1'b0, fx_s8[1][30:0]};
		if (f_lt(mg9, {1'b0, fx_s8[2][30:0]})) mg9 = {1'b0, fx_s8[2][30:0]};
		e9  = mg9[30:23];
		ee9 = (e9 == 8'd0) ? 8'd1 : e9;
		rr9 = shr_rne({40'd0, |e9, mg9[22:0]}, 7'(8'd24 - ee9));
		n9.fx[0] = fx_s8[0];
		n9.fx[1] = fx_s8[1];
		n9.fx[2] = fx_s8[2];
		n9.emax  = mm9;
		if (e9 == 8'hFF) n9.guard = f_nan(mg9) ? (mg9 | vsreb_pkg::F_QUIET_BIT) : mg9;
		else if (e9 >= 8'd24) n9.guard = {1'b0, e9 - 8'd23, mg9[22:0]};
		else n9.guard = {1'b0, 31'({8'd0, rr9.kept[22:0]}) + 31'(rr9.ru)};
	end

	// align and add the two nonnegative terms
	always_comb begin
		n10.fx = f_s9.fx;
		n10.spec = f_nan(f_s9.emax) || f_nan(f_s9.guard)
			|| (&f_s9.emax[30:23]) || (&f_s9.guard[30:23]);
		if (f_nan(f_s9.emax)) n10.spec_val = f_s9.emax | vsreb_pkg::F_QUIET_BIT;
		else if (f_nan(f_s9.guard)) n10.spec_val = f_s9.guard | vsreb_pkg::F_QUIET_BIT;
		else n10.spec_val = vsreb_pkg::F_INF;
		if (f_s9.emax[30:0] >= f_s9.guard[30:0]) begin
			lw10 = f_s9.emax;
			sw10 = f_s9.guard;
		end else begin
			lw10 = f_s9.guard;
			sw10 = f_s9.emax;
		end
		el10 = (lw10[30:23] == 8'd0) ? 8'd1 : lw10[30:23];
		es10 = (sw10[30:23] == 8'd0) ? 8'd1 : sw10[30:23];
		df10 = el10 - es10;
		d10  = (df10 > 8'd27) ? 5'd27 : df10[4:0];
		x10  = {|sw10[30:23], sw10[22:0], 3'b000};
		sh10 = x10 >> d10;
		n10.el  = el10;
		n10.sum = {1'b0, |lw10[30:23], lw10[22:0], 3'b000}
			+ {1'b0, sh10[26:1], sh10[0] | (|(x10 & ~({27{1'b1}} << d10)))};
	end

	// round and pack the bound
	always_comb begin
		if (f_s10.sum[27]) begin
			mant11 = f_s10.sum[27:4];
			g11    = f_s10.sum[3];
			st11   = |f_s10.sum[2:0];
			e11    = {1'b0, f_s10.el} + 9'd1;
		end else begin
			mant11 = f_s10.sum[26:3];
			g11    = f_s10.sum[2];
			st11   = |f_s10.sum[1:0];
			e11    = f_s10.sum[26] ? {1'b0, f_s10.el} : 9'd0;
		end
		ru11 = g11 & (st11 | mant11[0]);
		if (f_s10.spec) tot11 = f_s10.spec_val;
		else if (e11 >= 9'd255) tot11 = vsreb_pkg::F_INF;
		else tot11 = {1'b0, 31'({e11[7:0], mant11[22:0]}) + 31'(ru11)};
		n11.out_x       = f_s10.fx[0];
		n11.out_y       = f_s10.fx[1];
		n11.out_z       = f_s10.fx[2];
		n11.error_bound = precise_q ? tot11 : 32'd0;
	end

	always_ff @(posedge clk) begin
		if (adv[9]) f_s9 <= n9;
		if (adv[10]) f_s10 <= n10;
		if (adv[11]) out_s11 <= n11;
	end

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> stage_vld_q[1])
		else $error("input stalled with first stage empty");

	a_take_loads: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> stage_vld_q[1])
		else $error("accepted word not in first stage");

	a_bound_sign: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && precise_q |-> !out_word.error_bound[31])
		else $error("negative error bound");

	a_bound_special: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && precise_q && (&out_word.out_x[30:23])
		|-> (&out_word.error_bound[30:23]))
		else $error("x not finite but bound finite");

endmodule

`default_nettype wire

[tb/tb_vertex_shift_round_error_bound.sv]
// testbench for the vertex shift, single rounding and error bound pipeline
`timescale 1ns / 1ps

module tb_vertex_shift_round_error_bound;

	typedef struct {
		bit                    is_cfg;
		vsreb_pkg::cfg_idx_t   idx;
		logic [63:0]           data;
		vsreb_pkg::in_word_t   w;
		bit                    typed;
		vsreb_pkg::out_word_t  want;
	} stim_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	vsreb_pkg::cfg_idx_t   cfg_idx;
	logic [63:0]           cfg_data;
	logic                  in_valid;
	logic                  in_stall;
	vsreb_pkg::in_word_t   in_word;
	logic                  out_valid;
	logic                  out_stall;
	vsreb_pkg::out_word_t  out_word;

	logic [63:0]           center_x, center_y, center_z;
	logic                  precise;
	vsreb_pkg::out_word_t  pending_results[$];
	stim_row_t             stim_rows[$];
	int                    errors;
	int                    hold;
	bit                    no_idle;

	vertex_shift_round_error_bound dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
		.out_valid(out_valid), .out_stall(out_stall), .out_word(out_word)
	);

	always #5 clk = ~clk;

	function automatic bit d_is_nan(logic [63:0] d);
		return d[62:52] == 11'h7FF && d[51:0] != 0;
	endfunction

	function automatic bit d_is_inf(logic [63:0] d);
		return d[62:52] == 11'h7FF && d[51:0] == 0;
	endfunction

	function automatic bit f_is_nan(logic [31:0] f);
		return f[30:23] == 8'hFF && f[22:0] != 0;
	endfunction

	// double subtract with x86-style nan propagation
	function automatic logic [63:0] dsub(logic [63:0] a, logic [63:0] b);
		if (d_is_nan(a))
			return a | vsreb_pkg::D_QUIET_BIT;
		if (d_is_nan(b))
			return b | vsreb_pkg::D_QUIET_BIT;
		if (d_is_inf(a) && d_is_inf(b) && a[63] == b[63])
			return vsreb_pkg::D_DEFAULT_NAN;
		return $realtobits($bitstoreal(a) - $bitstoreal(b));
	endfunction

	// double to single, round to nearest even
	function automatic logic [31:0] to_single(logic [63:0] b);
		int          e_unb;
		int          sh;
		logic [63:0] m, q, rem, half, r;
		if (d_is_nan(b))
			return {b[63], 8'hFF, 1'b1, b[50:29]};
		if (b[62:0] >= vsreb_pkg::D_NARROW_OVF)
			return {b[63], vsreb_pkg::F_INF[30:0]};
		e_unb = int'(b[62:52]) - 1023;
		if (b[62:52] == 0 || e_unb < -160)
			return {b[63], 31'b0};
		m = {11'b0, 1'b1, b[51:0]};
		sh = (e_unb >= -126) ? 29 : 29 + (-126 - e_unb);
		q = m >> sh;
		rem = m & ((64'd1 << sh) - 1);
		half = 64'd1 << (sh - 1);
		if (rem > half || (rem == half && q[0]))
			q = q + 1;
		if (e_unb >= -126)
			r = (64'(e_unb + 126) << 23) + q;
		else
			r = q;
		return {b[63], r[30:0]};
	endfunction

	function automatic logic [63:0] to_double(logic [31:0] f);
		int          k;
		logic [23:0] mm;
		if (f[30:23] == 8'hFF)
			return {f[31], 11'h7FF, f[22:0], 29'b0};
		if (f[30:0] == 0)
			return {f[31], 63'b0};
		if (f[30:23] == 0) begin
			k = 1;
			mm = {f[22:0], 1'b0};
			while (!mm[23]) begin
				mm = mm << 1;
				k++;
			end
			return {f[31], 11'(897 - k), mm[22:0], 29'b0};
		end
		return {f[31], 11'(f[30:23] + 896), f[22:0], 29'b0};
	endfunction

	function automatic bit d_less(logic [63:0] a, logic [63:0] b);
		if (d_is_nan(a) || d_is_nan(b))
			return 0;
		return $bitstoreal(a) < $bitstoreal(b);
	endfunction

	// first operand kept unless a later one compares greater
	function automatic logic [63:0] d_max3(logic [63:0] a, logic [63:0] b, logic [63:0] c);
		logic [63:0] m;
		m = a;
		if (d_less(m, b))
			m = b;
		if (d_less(m, c))
			m = c;
		return m;
	endfunction

	function automatic vsreb_pkg::out_word_t shift_round(vsreb_pkg::in_word_t w);
		vsreb_pkg::out_word_t r;
		logic [63:0] sx, sy, sz, emax;
		logic [31:0] mag, guard, lead;
		sx = dsub(w.coord_x, center_x);
		sy = dsub(w.coord_y, center_y);
		sz = dsub(w.coord_z, center_z);
		r.out_x = to_single(sx);
		r.out_y = to_single(sy);
		r.out_z = to_single(sz);
		r.error_bound = 32'h0;
		if (precise) begin
			emax = d_max3(dsub(sx, to_double(r.out_x)) & 64'h7FFF_FFFF_FFFF_FFFF,
				dsub(sy, to_double(r.out_y)) & 64'h7FFF_FFFF_FFFF_FFFF,
				dsub(sz, to_double(r.out_z)) & 64'h7FFF_FFFF_FFFF_FFFF);
			mag = to_single(d_max3(to_double({1'b0, r.out_x[30:0]}),
				to_double({1'b0, r.out_y[30:0]}), to_double({1'b0, r.out_z[30:0]})));
			if (f_is_nan(mag))
				guard = mag;
			else
				guard = to_single($realtobits($bitstoreal(to_double(mag))
					* 1.1920928955078125e-7));
			lead = to_single(emax);
			if (f_is_nan(lead))
				r.error_bound = lead;
			else if (f_is_nan(guard))
				r.error_bound = guard;
			else
				r.error_bound = to_single($realtobits($bitstoreal(to_double(lead))
					+ $bitstoreal(to_double(guard))));
		end
		return r;
	endfunction

	task automatic report(string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		errors++;
	endtask

	// output side: random stall and word check
	always @(posedge clk) begin
		vsreb_pkg::out_word_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (pending_results.size() == 0) begin
					report($sformatf("word %h with nothing pending", out_word));
				end else begin
					want = pending_results.pop_front();
					if (out_word.out_x !== want.out_x)
						report($sformatf("out_x %h want %h", out_word.out_x, want.out_x));
					if (out_word.out_y !== want.out_y)
						report($sformatf("out_y %h want %h", out_word.out_y, want.out_y));
					if (out_word.out_z !== want.out_z)
						report($sformatf("out_z %h want %h", out_word.out_z, want.out_z));
					if (out_word.error_bound !== want.error_bound)
						report($sformatf("error_bound %h want %h", out_word.error_bound,
							want.error_bound));
				end
				hold = no_idle ? 0 : $urandom_range(0, 17);
				out_stall <= (hold > 0);
			end else if (hold > 0) begin
				hold--;
				out_stall <= (hold > 0);
			end
		end
	end

	task automatic write_reg(vsreb_pkg::cfg_idx_t idx, logic [63:0] data);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			vsreb_pkg::CFG_CENTER_X: center_x = data;
			vsreb_pkg::CFG_CENTER_Y: center_y = data;
			vsreb_pkg::CFG_CENTER_Z: center_z = data;
			vsreb_pkg::CFG_PRECISE:  precise = data[0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	task automatic send(vsreb_pkg::in_word_t w, int gap, bit typed,
			vsreb_pkg::out_word_t want);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_word <= w;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pending_results.push_back(typed ? want : shift_round(w));
	endtask

	task automatic add_cfg(vsreb_pkg::cfg_idx_t idx, logic [63:0] data);
		stim_row_t r;
		r = '{default: '0};
		r.is_cfg = 1;
		r.idx = idx;
		r.data = data;
		stim_rows.push_back(r);
	endtask

	task automatic add_word(logic [63:0] x, logic [63:0] y, logic [63:0] z, bit typed,
			vsreb_pkg::out_word_t want);
		stim_row_t r;
		r = '{default: '0};
		r.w = '{x, y, z};
		r.typed = typed;
		r.want = want;
		stim_rows.push_back(r);
	endtask

	function automatic logic [63:0] special_double();
		case ($urandom_range(0, 12))
			0: return 64'h0;
			1: return 64'h8000_0000_0000_0000;
			2: return 64'h7FF0_0000_0000_0000;
			3: return 64'hFFF0_0000_0000_0000;
			4: return 64'h7FF8_0000_0000_0000;
			5: return {1'b1, 11'h7FF, 1'b0, 51'($urandom) | 51'd1};
			6: return 64'h47EF_FFFF_F000_0000;
			7: return 64'hC7EF_FFFF_EFFF_FFFF;
			8: return 64'h7FEF_FFFF_FFFF_FFFF;
			9: return 64'h0000_0000_0000_0001;
			10: return 64'h3690_0000_0000_0000;
			11: return 64'h36A0_0000_0000_0001;
			default: return 64'h3FF0_0000_1000_0000;
		endcase
	endfunction

	function automatic logic [63:0] rand_coord(logic [63:0] c);
		int e;
		case ($urandom_range(0, 9))
			0, 1: return {$urandom, $urandom};
			2, 3, 4, 5: begin
				e = (c[62:52] == 0 || c[62:52] == 11'h7FF) ? 1023 : int'(c[62:52]);
				e = e + $urandom_range(0, 6) - 3;
				if (e < 1) e = 1;
				if (e > 2046) e = 2046;
				return {1'($urandom), 11'(e), 20'($urandom), $urandom};
			end
			6: return special_double();
			7: return {1'($urandom), 11'(897 - $urandom_range(0, 30)), 20'($urandom), $urandom};
			default: return {1'($urandom), 11'(1023 + $urandom_range(0, 60) - 30),
				20'($urandom), $urandom};
		endcase
	endfunction

	function automatic logic [63:0] rand_center(int phase);
		case (phase)
			0: return 64'h0;
			1: return 64'hFFFF_FFFF_FFFF_FFFF;
			5: return 64'h7FF0_0000_0000_0000;
			6: return {$urandom, $urandom};
			default: return {1'($urandom), 11'(1023 + $urandom_range(0, 40) - 20),
				20'($urandom), $urandom};
		endcase
	endfunction

	initial begin
		vsreb_pkg::out_word_t nil;
		stim_row_t            r;
		vsreb_pkg::in_word_t  w;
		clk = 0;
		arst_n = 0;
		cfg_we = 0;
		cfg_idx = vsreb_pkg::CFG_CENTER_X;
		cfg_data = '0;
		in_valid = 0;
		in_word = '0;
		out_stall = 0;
		hold = 0;
		no_idle = 0;
		errors = 0;
		center_x = '0;
		center_y = '0;
		center_z = '0;
		precise = 0;
		nil = '0;

		add_word(64'h0, 64'h0, 64'h0, 1, nil);
		add_word(64'h7FF0_0000_0000_0000, 64'hFFF0_0000_0000_0000, 64'h7FF0_0000_0000_0001, 1,
			'{32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0000, 32'h0});
		add_word(64'h47EF_FFFF_F000_0000, 64'h47EF_FFFF_EFFF_FFFF, 64'hFFEF_FFFF_FFFF_FFFF, 1,
			'{32'h7F80_0000, 32'h7F7F_FFFF, 32'hFF80_0000, 32'h0});
		add_word(64'h0000_0000_0000_0001, 64'h8000_0000_0000_0000, 64'h3690_0000_0000_0000, 1,
			'{32'h0, 32'h8000_0000, 32'h0, 32'h0});
		add_cfg(vsreb_pkg::CFG_PRECISE, 64'h1);
		add_word(64'h3FF0_0000_0000_0000, 64'h3FF0_0000_0000_0001, 64'hBFF8_0000_0000_0000, 0, nil);
		add_word(64'h7FF0_0000_0000_0000, 64'h3690_0000_0000_0001, 64'h7FF8_0000_0000_0123, 0, nil);
		add_word(64'h7FFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 0, nil);
		add_word(64'h4000_0000_1000_0000, 64'h47EF_FFFF_F000_0000, 64'h0000_0000_0000_0001, 0, nil);
		add_word(64'h3810_0000_0800_0000, 64'h36A0_0000_0000_0001, 64'hC1E0_0000_0000_0001, 0, nil);
		add_cfg(vsreb_pkg::CFG_CENTER_X, 64'h7FF0_0000_0000_0000);
		add_word(64'h7FF0_0000_0000_0000, 64'h3FF0_0000_0000_0000, 64'h3FF0_0000_0000_0000, 0, nil);
		add_word(64'h3FF0_0000_0000_0000, 64'h4059_0000_0000_0000, 64'hC059_0000_0000_0000, 0, nil);
		add_cfg(vsreb_pkg::CFG_CENTER_Y, 64'h3FF0_0000_0000_0000);
		add_cfg(vsreb_pkg::CFG_CENTER_Z, 64'hFFFF_FFFF_FFFF_FFFF);
		add_word(64'hFFF0_0000_0000_0000, 64'h3FF0_0000_0000_0000, 64'h3FF0_0000_0000_0000, 0, nil);
		add_word(64'h0, 64'h3FF0_0000_0000_0001, 64'h7FF8_0000_0000_0000, 0, nil);
		add_cfg(vsreb_pkg::CFG_PRECISE, 64'h0);
		add_word(64'h4000_0000_0000_0000, 64'h3FF0_0000_2000_0000, 64'h0, 0, nil);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (stim_rows[i]) begin
			r = stim_rows[i];
			if (r.is_cfg) begin
				drain();
				write_reg(r.idx, r.data);
			end else begin
				send(r.w, $urandom_range(0, 17), r.typed, r.want);
			end
		end

		for (int phase = 0; phase < 8; phase++) begin
			drain();
			no_idle = (phase == 3);
			write_reg(vsreb_pkg::CFG_CENTER_X, rand_center(phase));
			write_reg(vsreb_pkg::CFG_CENTER_Y, rand_center(phase));
			write_reg(vsreb_pkg::CFG_CENTER_Z, rand_center(phase));
			write_reg(vsreb_pkg::CFG_PRECISE, (phase % 4 == 2) ? 64'h0 : 64'h1);
			for (int n = 0; n < 230; n++) begin
				if (phase == 4 && n == 115)
					drain();
				w.coord_x = rand_coord(center_x);
				w.coord_y = rand_coord(center_y);
				w.coord_z = rand_coord(center_z);
				send(w, no_idle ? 0 : $urandom_range(0, 17), 0, nil);
			end
		end

		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
